// ----- hw/rtl/trbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbf_pkg
// Shared types and byte codes for the telnet receive byte filter.
// ----------------------------------------------------------------------------
package trbf_pkg;

	// Telnet command bytes
	localparam logic [7:0] BYTE_IAC  = 8'hFF;
	localparam logic [7:0] BYTE_WILL = 8'hFB;
	localparam logic [7:0] BYTE_DONT = 8'hFE;
	localparam logic [7:0] BYTE_SB   = 8'hFA;
	localparam logic [7:0] BYTE_SE   = 8'hF0;

	// Line-ending bytes
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;

	// One received byte with its side flags
	typedef struct packed {
		logic       connection_start;
		logic       chunk_start;
		logic [7:0] data_byte;
	} rx_item_t;

	// Result of one filter pass
	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
	} filt_res_t;

endpackage

// ----- hw/rtl/trbf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbf_core
// Telnet command stripper and line-ending fixer, one byte per enabled cycle.
// Holds the command state and CR memory; result is combinational.
// ----------------------------------------------------------------------------
module trbf_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enable,
	input  logic                raw_mode,
	input  trbf_pkg::rx_item_t  item,
	output trbf_pkg::filt_res_t res
);
	import trbf_pkg::*;

	localparam logic [2:0] ST_TEXT   = 3'd0;
	localparam logic [2:0] ST_IAC    = 3'd1;
	localparam logic [2:0] ST_OPT    = 3'd2;
	localparam logic [2:0] ST_SB     = 3'd3;
	localparam logic [2:0] ST_SB_IAC = 3'd4;

	logic [2:0] state_q;
	logic       last_cr_q;
	logic [2:0] cur_state;
	logic       cur_cr;
	logic [2:0] nxt_state;
	logic       nxt_cr;
	logic       mid_ok;
	logic [7:0] b;

	assign b = item.data_byte;

	// Start flags clear state before the byte is handled
	assign cur_state = item.connection_start ? ST_TEXT : state_q;
	assign cur_cr    = item.chunk_start ? 1'b0 : last_cr_q;

	// Command stripper
	always_comb begin
		nxt_state = cur_state;
		mid_ok    = 1'b0;
		unique case (cur_state)
			ST_IAC: begin
				if (b == BYTE_IAC) begin
					mid_ok    = 1'b1;
					nxt_state = ST_TEXT;
				end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
					nxt_state = ST_OPT;
				end else if (b == BYTE_SB) begin
					nxt_state = ST_SB;
				end else begin
					nxt_state = ST_TEXT;
				end
			end
			ST_OPT: begin
				nxt_state = ST_TEXT;
			end
			ST_SB: begin
				if (b == BYTE_IAC) begin
					nxt_state = ST_SB_IAC;
				end
			end
			ST_SB_IAC: begin
				nxt_state = (b == BYTE_SE) ? ST_TEXT : ST_SB;
			end
			default: begin
				// text state; unused codes behave the same
				if (b == BYTE_IAC) begin
					nxt_state = ST_IAC;
				end else begin
					mid_ok = 1'b1;
				end
			end
		endcase
	end

	// Line-ending fixer and raw bypass
	always_comb begin
		nxt_cr       = cur_cr;
		res.emit     = 1'b0;
		res.out_byte = b;
		if (raw_mode) begin
			res.emit = 1'b1;
		end else if (mid_ok && b != BYTE_NUL) begin
			if (b == BYTE_LF && cur_cr) begin
				nxt_cr = 1'b0;
			end else begin
				nxt_cr       = (b == BYTE_CR);
				res.emit     = 1'b1;
				res.out_byte = (b == BYTE_LF) ? BYTE_CR : b;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_TEXT;
			last_cr_q <= 1'b0;
		end else if (enable) begin
			state_q   <= raw_mode ? cur_state : nxt_state;
			last_cr_q <= raw_mode ? cur_cr : nxt_cr;
		end
	end

endmodule

// ----- hw/rtl/telnet_rx_byte_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_rx_byte_filter_unit
// Telnet receive byte filter: strips commands, fixes line endings.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the output side is not backed up, and gives
// zero or one byte for it. A request is captured in an input register,
// filtered in one pass of the core, and the result lands in an output
// register; the sustained rate is one byte per clock, set by the update of
// the command state and CR memory. Bytes that are swallowed (commands, NUL,
// LF after CR) simply produce no output request. raw_mode should only be
// written while the block is idle.
module telnet_rx_byte_filter_unit (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_wdata,      // raw_mode
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,        // [7:0] data_byte
	input  logic [1:0] s_tuser,        // [0] chunk_start, [1] connection_start
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata         // [7:0] out_byte
);
	import trbf_pkg::*;

	logic      raw_mode_q;
	logic      valid_s1;
	rx_item_t  item_s1;
	logic      advance;
	filt_res_t res;
	logic      out_valid_q;
	logic [7:0] out_byte_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
		end else if (cfg_we) begin
			raw_mode_q <= cfg_wdata;
		end
	end

	// Stage 1 moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte        <= s_tdata;
			item_s1.chunk_start      <= s_tuser[0];
			item_s1.connection_start <= s_tuser[1];
		end
	end

	trbf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (advance),
		.raw_mode (raw_mode_q),
		.item     (item_s1),
		.res      (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_byte_q <= res.out_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

`ifndef NO_ASSERTIONS
	// A new output request only follows a filtered byte
	a_out_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(advance))
		else $error("output request without a filtered byte");

	// Raw mode passes the byte straight through
	a_raw_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && raw_mode_q) |=> (m_tvalid && m_tdata == $past(item_s1.data_byte)))
		else $error("raw byte not passed through");

	// Filtered output never carries NUL or LF
	a_clean_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !raw_mode_q) |-> (m_tdata != BYTE_NUL && m_tdata != BYTE_LF))
		else $error("NUL or LF leaked through filter");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the telnet receive byte filter.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a clocked driver. Every byte the block
// accepts is run through an in-bench filter model, which queues the cleaned
// byte (if any) that the block should emit. The monitor compares each output
// request with the oldest queued byte. The run starts with directed telnet
// and line-ending cases in both modes, then runs random phases of mostly
// well-formed command sequences. Raw mode changes only between phases, with
// the block drained. Both sides idle at random, and in one phase the output
// side holds off long enough for the block to back up.
module testbench;
	import trbf_pkg::*;

	// Command stripper states of the filter model
	typedef enum logic [2:0] {
		CMD_TEXT   = 3'd0,
		CMD_IAC    = 3'd1,
		CMD_OPT    = 3'd2,
		CMD_SB     = 3'd3,
		CMD_SB_IAC = 3'd4
	} cmd_state_e;

	localparam int unsigned PHASE_ITEMS = 215;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_WAIT  = 4;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;
	logic [1:0] s_tuser   = 2'b00;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;

	// Filter model state and its copy of the register
	cmd_state_e cmd_state   = CMD_TEXT;
	logic       cr_seen     = 1'b0;
	logic       raw_mode_q  = 1'b0;

	rx_item_t   rx_bytes_q[$];
	logic [7:0] clean_bytes_q[$];
	rx_item_t   cur_item;
	bit         req_taken   = 1'b0;
	bit         src_idle_on = 1'b1;
	bit         snk_idle_on = 1'b1;
	bit         stall_armed = 1'b0;
	int unsigned stall_at   = 0;
	int unsigned accepted_total = 0;
	int unsigned src_gap    = 0;
	int unsigned snk_gap    = 0;
	int unsigned hold_left  = 0;
	int unsigned mismatch_cnt = 0;

	telnet_rx_byte_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	// Mostly no gap, some short, a few long
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Filter model: one accepted byte, queues the cleaned byte if one comes out
	task automatic filter_byte(input rx_item_t it);
		logic [7:0] b;
		logic [7:0] mid;
		logic       pass;
		b    = it.data_byte;
		mid  = BYTE_NUL;
		pass = 1'b0;
		if (it.connection_start)
			cmd_state = CMD_TEXT;
		if (it.chunk_start)
			cr_seen = 1'b0;
		if (raw_mode_q) begin
			clean_bytes_q.insert(clean_bytes_q.size(), b);
			return;
		end
		// telnet command stripping
		case (cmd_state)
			CMD_IAC: begin
				if (b == BYTE_IAC) begin
					mid       = BYTE_IAC;
					pass      = 1'b1;
					cmd_state = CMD_TEXT;
				end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
					cmd_state = CMD_OPT;
				end else if (b == BYTE_SB) begin
					cmd_state = CMD_SB;
				end else begin
					cmd_state = CMD_TEXT;
				end
			end
			CMD_OPT: cmd_state = CMD_TEXT;
			CMD_SB: begin
				if (b == BYTE_IAC)
					cmd_state = CMD_SB_IAC;
			end
			CMD_SB_IAC: cmd_state = (b == BYTE_SE) ? CMD_TEXT : CMD_SB;
			default: begin
				if (b == BYTE_IAC) begin
					cmd_state = CMD_IAC;
				end else begin
					mid  = b;
					pass = 1'b1;
				end
			end
		endcase
		// line-ending fix-up
		if (!pass || mid == BYTE_NUL)
			return;
		if (mid == BYTE_LF && cr_seen) begin
			cr_seen = 1'b0;
			return;
		end
		cr_seen = (mid == BYTE_CR);
		clean_bytes_q.insert(clean_bytes_q.size(), (mid == BYTE_LF) ? BYTE_CR : mid);
	endtask

	// Acceptance of a request on the input side
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			filter_byte(cur_item);
			accepted_total++;
			req_taken = 1'b1;
		end
	end

	// Driver: holds a request until taken, then offers the next after a random, possibly empty, gap
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !req_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (rx_bytes_q.size() > 0) begin
				cur_item = rx_bytes_q[0];
				rx_bytes_q.delete(0);
				s_tvalid <= 1'b1;
				s_tdata  <= cur_item.data_byte;
				s_tuser  <= {cur_item.connection_start, cur_item.chunk_start};
				src_gap  = src_idle_on ? draw_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// Output side readiness, with one long hold-off when armed
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_armed && accepted_total >= stall_at) begin
				stall_armed = 1'b0;
				hold_left   = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				snk_gap = snk_idle_on ? draw_gap() : 0;
			end
		end
	end

	// Monitor: each output request against the oldest queued byte
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (clean_bytes_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h", m_tdata));
			end else begin
				want = clean_bytes_q[0];
				clean_bytes_q.delete(0);
				if (m_tdata !== want)
					report_mismatch($sformatf("out_byte got %02h want %02h", m_tdata, want));
			end
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic cs = 1'b0, input logic cn = 1'b0);
		rx_item_t it;
		it.data_byte        = b;
		it.chunk_start      = cs;
		it.connection_start = cn;
		rx_bytes_q.insert(rx_bytes_q.size(), it);
	endtask

	// Random byte with occasional chunk and connection starts
	task automatic add_rand_flags(input logic [7:0] b);
		add_byte(b, $urandom_range(0, 19) == 0, $urandom_range(0, 49) == 0);
	endtask

	// One random sequence: mostly well-formed telnet, some noise
	task automatic add_random_seq();
		int unsigned kind;
		int unsigned n;
		int unsigned r;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			n = $urandom_range(1, 8);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					b = BYTE_CR;
				else if (r < 18)
					b = BYTE_LF;
				else if (r < 22)
					b = BYTE_NUL;
				else
					b = 8'($urandom_range(0, 254));
				add_rand_flags(b);
			end
		end else if (kind < 45) begin
			case ($urandom_range(0, 3))
				0: begin
					add_rand_flags(BYTE_CR);
					add_rand_flags(BYTE_LF);
				end
				1: begin
					add_rand_flags(BYTE_CR);
					add_rand_flags(BYTE_NUL);
					add_rand_flags(BYTE_LF);
				end
				2: add_rand_flags(BYTE_LF);
				default: begin
					add_rand_flags(BYTE_CR);
					add_rand_flags(BYTE_CR);
					add_rand_flags(BYTE_LF);
				end
			endcase
		end else if (kind < 53) begin
			add_rand_flags(BYTE_IAC);
			add_rand_flags(BYTE_IAC);
		end else if (kind < 68) begin
			add_rand_flags(BYTE_IAC);
			add_rand_flags(8'($urandom_range(BYTE_WILL, BYTE_DONT)));
			add_rand_flags(8'($urandom_range(0, 255)));
		end else if (kind < 80) begin
			// subnegotiation with random payload, stray IACs inside
			add_rand_flags(BYTE_IAC);
			add_rand_flags(BYTE_SB);
			n = $urandom_range(0, 6);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					add_rand_flags(BYTE_IAC);
					b = 8'($urandom_range(0, 255));
					add_rand_flags((b == BYTE_SE) ? BYTE_IAC : b);
				end else begin
					add_rand_flags(8'($urandom_range(0, 254)));
				end
			end
			add_rand_flags(BYTE_IAC);
			add_rand_flags(BYTE_SE);
		end else if (kind < 88) begin
			add_rand_flags(BYTE_IAC);
			add_rand_flags(8'($urandom_range(8'hF0, 8'hF9)));
		end else begin
			n = $urandom_range(1, 4);
			repeat (n)
				add_rand_flags(8'($urandom_range(0, 255)));
		end
	endtask

	// Wait until every request is taken and every cleaned byte has come out
	task automatic drain();
		while (rx_bytes_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (clean_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_raw_mode(input logic v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		raw_mode_q = v;
	endtask

	// Main sequence
	initial begin
		int unsigned target;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed, filtering on
		write_raw_mode(1'b0);
		add_byte(8'h41);
		add_byte(BYTE_NUL);
		add_byte(BYTE_IAC);  add_byte(BYTE_IAC);
		add_byte(BYTE_IAC);  add_byte(BYTE_WILL); add_byte(8'h01);
		add_byte(BYTE_IAC);  add_byte(BYTE_DONT); add_byte(BYTE_IAC);
		add_byte(BYTE_IAC);  add_byte(BYTE_SB);   add_byte(8'h18);
		add_byte(BYTE_IAC);  add_byte(BYTE_NUL);  add_byte(BYTE_IAC);
		add_byte(BYTE_SE);
		add_byte(BYTE_CR);   add_byte(BYTE_LF);
		add_byte(BYTE_LF);
		add_byte(BYTE_CR);   add_byte(BYTE_NUL);  add_byte(BYTE_LF);
		add_byte(BYTE_CR);   add_byte(BYTE_LF, 1'b1);
		add_byte(BYTE_IAC);  add_byte(8'h41, 1'b0, 1'b1);
		add_byte(BYTE_CR);   add_byte(BYTE_IAC);  add_byte(BYTE_LF, 1'b1, 1'b1);
		add_byte(BYTE_IAC);  add_byte(8'hF1);
		add_byte(8'h80);
		add_byte(BYTE_IAC);
		drain();

		// directed, raw mode: start flags still clear state left mid-command
		write_raw_mode(1'b1);
		add_byte(BYTE_IAC);
		add_byte(BYTE_NUL, 1'b1);
		add_byte(BYTE_LF);
		add_byte(BYTE_CR, 1'b0, 1'b1);
		add_byte(8'h7F);
		drain();
		write_raw_mode(1'b0);
		add_byte(BYTE_LF);
		add_byte(BYTE_LF);
		drain();

		// random phases
		for (int p = 0; p < 8; p++) begin
			write_raw_mode((p % 3) == 1);
			src_idle_on = (p != 2 && p != 5 && p != 6);
			snk_idle_on = (p != 2 && p != 5 && p != 3);
			if (p == 2) begin
				stall_at    = accepted_total + 20;
				stall_armed = 1'b1;
			end
			target = accepted_total + PHASE_ITEMS;
			while (accepted_total + rx_bytes_q.size() < target)
				add_random_seq();
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
